>>> hdl/rgb_pair_to_ycbcr422_macros.svh
`ifndef RGB_PAIR_TO_YCBCR422_MACROS_SVH
`define RGB_PAIR_TO_YCBCR422_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define YCC422_CHECK_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define YCC422_CHECK_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> hdl/ycc422_pkg.sv
`default_nettype none

package ycc422_pkg;

   // Component and result widths.
   localparam int unsigned CompWidth  = 8;
   localparam int unsigned PairWidth  = 6 * CompWidth;
   localparam int unsigned WordWidth  = 4 * CompWidth;
   localparam int unsigned LumaWidth  = 18;
   localparam int unsigned ChromWidth = 25;

   // Luma coefficients, numerator at most 255 * 1000.
   localparam logic [LumaWidth-1:0] LumaKr = 18'd299;
   localparam logic [LumaWidth-1:0] LumaKg = 18'd587;
   localparam logic [LumaWidth-1:0] LumaKb = 18'd114;

   // Chroma coefficients and bias, numerators stay below 2^25.
   localparam logic [ChromWidth-1:0] CbKr       = 25'd16874;
   localparam logic [ChromWidth-1:0] CbKg       = 25'd33126;
   localparam logic [ChromWidth-1:0] CbKb       = 25'd50000;
   localparam logic [ChromWidth-1:0] CrKr       = 25'd50000;
   localparam logic [ChromWidth-1:0] CrKg       = 25'd41869;
   localparam logic [ChromWidth-1:0] CrKb       = 25'd8131;
   localparam logic [ChromWidth-1:0] ChromaBias = 25'd12800000;

   // Reciprocals: ceil(2^28 / 1000) and ceil(2^41 / 100000). Both are exact
   // over the full numerator range, so no correction step is needed.
   localparam logic [18:0] LumaRecip  = 19'd268436;
   localparam int unsigned LumaShift  = 28;
   localparam logic [24:0] ChromRecip = 25'd21990233;
   localparam int unsigned ChromShift = 41;

   typedef struct packed {
      logic [CompWidth-1:0] blue_second;
      logic [CompWidth-1:0] green_second;
      logic [CompWidth-1:0] red_second;
      logic [CompWidth-1:0] blue_first;
      logic [CompWidth-1:0] green_first;
      logic [CompWidth-1:0] red_first;
   } pair_type;

   typedef struct packed {
      logic [LumaWidth-1:0]  luma_first;
      logic [LumaWidth-1:0]  luma_second;
      logic [ChromWidth-1:0] cb_first;
      logic [ChromWidth-1:0] cb_second;
      logic [ChromWidth-1:0] cr_first;
      logic [ChromWidth-1:0] cr_second;
   } numer_type;

   typedef struct packed {
      logic [CompWidth-1:0] y_first;
      logic [CompWidth-1:0] y_second;
      logic [CompWidth-1:0] cb_first;
      logic [CompWidth-1:0] cb_second;
      logic [CompWidth-1:0] cr_first;
      logic [CompWidth-1:0] cr_second;
   } quot_type;

   function automatic logic [LumaWidth-1:0] luma_numer(
      input logic [CompWidth-1:0] r,
      input logic [CompWidth-1:0] g,
      input logic [CompWidth-1:0] b
   );
      return LumaKr * {10'd0, r} + LumaKg * {10'd0, g} + LumaKb * {10'd0, b};
   endfunction

   function automatic logic [ChromWidth-1:0] cb_numer(
      input logic [CompWidth-1:0] r,
      input logic [CompWidth-1:0] g,
      input logic [CompWidth-1:0] b
   );
      logic [ChromWidth-1:0] pos;
      logic [ChromWidth-1:0] neg;
      pos = CbKb * {17'd0, b} + ChromaBias;
      neg = CbKr * {17'd0, r} + CbKg * {17'd0, g};
      return pos - neg;
   endfunction

   function automatic logic [ChromWidth-1:0] cr_numer(
      input logic [CompWidth-1:0] r,
      input logic [CompWidth-1:0] g,
      input logic [CompWidth-1:0] b
   );
      logic [ChromWidth-1:0] pos;
      logic [ChromWidth-1:0] neg;
      pos = CrKr * {17'd0, r} + ChromaBias;
      neg = CrKg * {17'd0, g} + CrKb * {17'd0, b};
      return pos - neg;
   endfunction

   // Divide a luma numerator by 1000 through its reciprocal.
   function automatic logic [CompWidth-1:0] luma_div(input logic [LumaWidth-1:0] n);
      logic [36:0] prod;
      prod = {19'd0, n} * {18'd0, LumaRecip};
      return prod[LumaShift +: CompWidth];
   endfunction

   // Divide a chroma numerator by 100000 through its reciprocal.
   function automatic logic [CompWidth-1:0] chrom_div(input logic [ChromWidth-1:0] n);
      logic [49:0] prod;
      prod = {25'd0, n} * {25'd0, ChromRecip};
      return prod[ChromShift +: CompWidth];
   endfunction

endpackage

`default_nettype wire

>>> hdl/ycc422_numer.sv
`default_nettype none

module ycc422_numer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire ycc422_pkg::pair_type  in_pair,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output ycc422_pkg::numer_type      out_numer
);
   import ycc422_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   numer_type numer_ff;
   numer_type numer_in;

   // The stage takes a beat when it is empty or its content moves on.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Weighted sums for both pixels of the pair.
   always_comb begin
      numer_in.luma_first  = luma_numer(in_pair.red_first, in_pair.green_first,
                                        in_pair.blue_first);
      numer_in.luma_second = luma_numer(in_pair.red_second, in_pair.green_second,
                                        in_pair.blue_second);
      numer_in.cb_first    = cb_numer(in_pair.red_first, in_pair.green_first,
                                      in_pair.blue_first);
      numer_in.cb_second   = cb_numer(in_pair.red_second, in_pair.green_second,
                                      in_pair.blue_second);
      numer_in.cr_first    = cr_numer(in_pair.red_first, in_pair.green_first,
                                      in_pair.blue_first);
      numer_in.cr_second   = cr_numer(in_pair.red_second, in_pair.green_second,
                                      in_pair.blue_second);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         numer_ff <= numer_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_numer = numer_ff;

endmodule

`default_nettype wire

>>> hdl/ycc422_recip.sv
`default_nettype none

module ycc422_recip (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire ycc422_pkg::numer_type  in_numer,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output ycc422_pkg::quot_type        out_quot
);
   import ycc422_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   quot_type quot_ff;
   quot_type quot_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Truncating divisions as reciprocal multiplies, one per component.
   always_comb begin
      quot_in.y_first   = luma_div(in_numer.luma_first);
      quot_in.y_second  = luma_div(in_numer.luma_second);
      quot_in.cb_first  = chrom_div(in_numer.cb_first);
      quot_in.cb_second = chrom_div(in_numer.cb_second);
      quot_in.cr_first  = chrom_div(in_numer.cr_first);
      quot_in.cr_second = chrom_div(in_numer.cr_second);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         quot_ff <= quot_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_quot  = quot_ff;

endmodule

`default_nettype wire

>>> hdl/ycc422_pack.sv
`default_nettype none

module ycc422_pack (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  in_valid,
   output logic                                       in_ready,
   input  wire ycc422_pkg::quot_type                  in_quot,
   output logic                                       out_valid,
   input  wire logic                                  out_ready,
   output logic [ycc422_pkg::WordWidth-1:0]           out_word
);
   import ycc422_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   logic [WordWidth-1:0] word_ff;
   logic [WordWidth-1:0] word_in;
   logic [CompWidth:0]   cb_sum;
   logic [CompWidth:0]   cr_sum;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Average the two chroma samples and pack Y1, Cb, Y2, Cr from the top down.
   always_comb begin
      cb_sum  = {1'b0, in_quot.cb_first} + {1'b0, in_quot.cb_second};
      cr_sum  = {1'b0, in_quot.cr_first} + {1'b0, in_quot.cr_second};
      word_in = {in_quot.y_first, cb_sum[CompWidth:1],
                 in_quot.y_second, cr_sum[CompWidth:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

>>> hdl/rgb_pair_to_ycbcr422.sv
// RGB pixel pair to packed YCbCr 4:2:2 converter. Each input beat carries two
// horizontally adjacent 8-bit RGB pixels; each output beat carries one 32-bit
// word {Y1, Cb, Y2, Cr} with Y1 in the top byte. Luma is (299R+587G+114B)/1000
// per pixel, chroma is the truncated full-range BT.601 value of each pixel,
// averaged over the pair. The block accepts one pair every clock cycle while
// rsp_tready holds or a stage is free, and passes it through three register
// stages: the accepting edge loads the sum register, and the word then moves
// through the divide and pack registers onto rsp_tdata. One stage forms the
// weighted sums, one divides them through reciprocal multiplies, and one
// averages and packs into the output register. Each stage holds its beat
// under backpressure and refills as soon as it empties, so idle stages never
// hold up input.
`default_nettype none
`include "rgb_pair_to_ycbcr422_macros.svh"

module rgb_pair_to_ycbcr422 (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // red_first, green_first, blue_first, red_second, green_second, blue_second
   input  wire logic [ycc422_pkg::PairWidth-1:0]   req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // ycbcr_word
   output logic [ycc422_pkg::WordWidth-1:0]        rsp_tdata
);
   import ycc422_pkg::*;

   pair_type  pair;
   numer_type numer;
   quot_type  quot;
   logic      numer_valid;
   logic      numer_ready;
   logic      quot_valid;
   logic      quot_ready;

   // Input fields sit in tdata from the lowest byte up.
   assign pair.red_first    = req_tdata[0*CompWidth +: CompWidth];
   assign pair.green_first  = req_tdata[1*CompWidth +: CompWidth];
   assign pair.blue_first   = req_tdata[2*CompWidth +: CompWidth];
   assign pair.red_second   = req_tdata[3*CompWidth +: CompWidth];
   assign pair.green_second = req_tdata[4*CompWidth +: CompWidth];
   assign pair.blue_second  = req_tdata[5*CompWidth +: CompWidth];

   ycc422_numer u_numer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pair   (pair),
      .out_valid (numer_valid),
      .out_ready (numer_ready),
      .out_numer (numer)
   );

   ycc422_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (numer_valid),
      .in_ready  (numer_ready),
      .in_numer  (numer),
      .out_valid (quot_valid),
      .out_ready (quot_ready),
      .out_quot  (quot)
   );

   ycc422_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (quot_valid),
      .in_ready  (quot_ready),
      .in_quot   (quot),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rsp_tdata)
   );

   // Input is refused only when every stage holds a beat and output is stalled.
   `YCC422_CHECK_NOW(a_full_when_blocked, !req_tready,
      numer_valid && quot_valid && rsp_tvalid && !rsp_tready,
      "input refused while the pipeline has a free stage")

   // An accepted pair always lands in the first stage.
   `YCC422_CHECK_NEXT(a_accept_lands, req_tvalid && req_tready, numer_valid,
      "accepted pair missing from the first stage")

   // A beat leaving the sum stage always lands in the divide stage.
   `YCC422_CHECK_NEXT(a_sum_moves, numer_valid && numer_ready, quot_valid,
      "beat lost between the sum and divide stages")

endmodule

`default_nettype wire
